// ===== hdl/markup_tag_stripper_core_assert.svh =====
// Assertion macros shared by the tag stripper queue and back-end modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef MARKUP_TAG_STRIPPER_CORE_ASSERT_SVH
`define MARKUP_TAG_STRIPPER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define MTS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mts assertion failed");

// An implication that must hold at every clock edge outside reset.
`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mts assertion failed");

`else

`define MTS_ASSERT(label, clk, rst_n, prop)
`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/mts_pkg.sv =====
package mts_pkg;

  // Largest number of output characters one input item can cause.
  localparam int unsigned MaxRun  = 6;
  localparam int unsigned RunCntW = 3;

  // One input item.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       text_done;
    logic       last_of_run;
  } out_item_t;

  // All characters caused by one input item, handed from front to back.
  typedef struct packed {
    logic [MaxRun-1:0][7:0] chars;
    logic [RunCntW-1:0]     count;
    logic                   char_valid;
    logic                   done;
  } run_t;

  // Entity index order: lt, gt, amp, quot.
  function automatic logic [7:0] ent_letter(input logic [1:0] ent, input logic [1:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case ({ent, pos})
      4'b00_00: ch = "l";
      4'b00_01: ch = "t";
      4'b01_00: ch = "g";
      4'b01_01: ch = "t";
      4'b10_00: ch = "a";
      4'b10_01: ch = "m";
      4'b10_10: ch = "p";
      4'b11_00: ch = "q";
      4'b11_01: ch = "u";
      4'b11_10: ch = "o";
      4'b11_11: ch = "t";
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] ent_len(input logic [1:0] ent);
    logic [2:0] len;
    unique case (ent)
      2'd0:    len = 3'd2;
      2'd1:    len = 3'd2;
      2'd2:    len = 3'd3;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] ent_char(input logic [1:0] ent);
    logic [7:0] ch;
    unique case (ent)
      2'd0:    ch = "<";
      2'd1:    ch = ">";
      2'd2:    ch = "&";
      default: ch = 8'h22;
    endcase
    return ch;
  endfunction

  // Letters of the break tag after the opening bracket.
  function automatic logic [7:0] brk_letter(input logic [1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      2'd0:    ch = "b";
      2'd1:    ch = "r";
      2'd2:    ch = "/";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Lower-case fold of ASCII capitals.
  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

// ===== hdl/markup_tag_stripper_core.sv =====
// Markup tag stripper for subtitle text.
// Input channel (in_valid_i / in_stall_o / in_item_i): one text byte per item,
// with byte_present and end_of_text flags. Output channel (out_valid_o /
// out_stall_i / out_item_o): one plain text byte per item, with flags for the
// last result of an input item and the final result of the string.
// A front parser takes one input item per cycle while the run queue is not
// full, strips tags, decodes the four entities and hands the characters each
// byte causes to a run queue of QueueDepth entries. A back serializer drains
// that queue one result per cycle through an output register while the
// receiver does not stall. A byte's first result passes through the queue and
// then the output register. Throughput is one input item per cycle while each
// causes at most one result and the receiver does not stall; a broken entity
// causes up to six results; the queue absorbs them while the front accepts.
// in_stall_o rises only when the run queue is full. When the receiver stalls,
// the output item holds and the queue fills behind it.
// Reset returns the parser to normal text mode and empties the queue and the
// output register.
module markup_tag_stripper_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mts_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mts_pkg::out_item_t out_item_o
);
  import mts_pkg::*;

  logic  accept;
  logic  push;
  run_t  push_run;
  logic  full;
  logic  empty;
  logic  pop;
  run_t  head;

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  mts_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (push),
    .run_o    (push_run)
  );

  mts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_run),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  mts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== hdl/mts_front.sv =====
module mts_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  mts_pkg::in_item_t item_i,
  output logic             push_o,
  output mts_pkg::run_t    run_o
);
  import mts_pkg::*;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_TAG    = 2'd1;
  localparam logic [1:0] MODE_ENTITY = 2'd2;

  logic [1:0] mode_q, mode_d;
  logic [2:0] tpos_q, tpos_d;
  logic       tbrk_q, tbrk_d;
  logic [3:0] cand_q, cand_d;
  logic [2:0] hcnt_q, hcnt_d;
  logic [3:0][7:0] held_q, held_d;

  logic [MaxRun-1:0][7:0] chars;
  logic [RunCntW-1:0]     n;
  logic                   run_valid;

  // Parse one item: update the parse state and collect the characters it causes.
  always_comb begin
    logic [7:0] c;
    logic [7:0] lc;
    logic       do_normal;
    logic       do_flush;
    logic       term_hit;
    logic [3:0] nxt;

    mode_d    = mode_q;
    tpos_d    = tpos_q;
    tbrk_d    = tbrk_q;
    cand_d    = cand_q;
    hcnt_d    = hcnt_q;
    held_d    = held_q;
    chars     = '0;
    n         = '0;
    run_valid = 1'b1;
    c         = item_i.text_byte;
    lc        = fold(c);
    do_normal = 1'b0;
    do_flush  = 1'b0;
    term_hit  = 1'b0;
    nxt       = '0;

    if (item_i.byte_present) begin
      unique case (mode_q)
        MODE_TAG: begin
          if (c == ">") begin
            if (tbrk_q && tpos_q == 3'd3) begin
              chars[n] = 8'h0A;
              n = n + 3'd1;
            end
            mode_d = MODE_NORMAL;
            tpos_d = '0;
            tbrk_d = 1'b1;
          end else if (tpos_q < 3'd3 && lc == brk_letter(tpos_q[1:0])) begin
            tpos_d = tpos_q + 3'd1;
          end else begin
            tbrk_d = 1'b0;
          end
        end
        MODE_ENTITY: begin
          // A terminator closes the first entity whose whole name was held.
          for (int i = 0; i < 4; i++) begin
            if (!term_hit && cand_q[i] && hcnt_q == ent_len(2'(i)) && c == ";") begin
              term_hit = 1'b1;
              chars[n] = ent_char(2'(i));
              n = n + 3'd1;
            end
          end
          for (int i = 0; i < 4; i++) begin
            if (cand_q[i] && hcnt_q < ent_len(2'(i)) &&
                ent_letter(2'(i), hcnt_q[1:0]) == lc) begin
              nxt[i] = 1'b1;
            end
          end
          if (term_hit) begin
            mode_d = MODE_NORMAL;
            tpos_d = '0;
            tbrk_d = 1'b1;
            cand_d = '0;
            hcnt_d = '0;
          end else if (nxt != 4'd0 && hcnt_q < 3'd4) begin
            held_d[hcnt_q[1:0]] = c;
            hcnt_d = hcnt_q + 3'd1;
            cand_d = nxt;
          end else begin
            do_flush  = 1'b1;
            do_normal = 1'b1;
          end
        end
        default: begin
          do_normal = 1'b1;
        end
      endcase
    end

    // A broken entity replays the ampersand and its held letters.
    if (do_flush) begin
      chars[n] = "&";
      n = n + 3'd1;
      for (int i = 0; i < 4; i++) begin
        if (i < int'(hcnt_q)) begin
          chars[n] = held_q[i[1:0]];
          n = n + 3'd1;
        end
      end
      mode_d = MODE_NORMAL;
      tpos_d = '0;
      tbrk_d = 1'b1;
      cand_d = '0;
      hcnt_d = '0;
    end

    // Byte seen in normal text, also the byte that broke an entity.
    if (do_normal) begin
      if (c == "<") begin
        mode_d = MODE_TAG;
        tpos_d = '0;
        tbrk_d = 1'b1;
      end else if (c == "&") begin
        mode_d = MODE_ENTITY;
        cand_d = 4'hF;
        hcnt_d = '0;
      end else begin
        chars[n] = c;
        n = n + 3'd1;
      end
    end

    // End of text flushes a pending entity and returns to the reset state.
    if (item_i.end_of_text) begin
      if (mode_d == MODE_ENTITY) begin
        if (n < RunCntW'(MaxRun)) begin
          chars[n] = "&";
          n = n + 3'd1;
        end
        for (int i = 0; i < 4; i++) begin
          if (i < int'(hcnt_d) && n < RunCntW'(MaxRun)) begin
            chars[n] = held_d[i[1:0]];
            n = n + 3'd1;
          end
        end
      end
      mode_d = MODE_NORMAL;
      tpos_d = '0;
      tbrk_d = 1'b1;
      cand_d = '0;
      hcnt_d = '0;
      if (n == '0) begin
        n         = 3'd1;
        run_valid = 1'b0;
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      tpos_q <= '0;
      tbrk_q <= 1'b1;
      cand_q <= '0;
      hcnt_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      tpos_q <= tpos_d;
      tbrk_q <= tbrk_d;
      cand_q <= cand_d;
      hcnt_q <= hcnt_d;
    end
  end

  // Held entity letters carry no reset; each is read only after it is written.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

  assign push_o           = accept_i && (n != '0);
  assign run_o.chars      = chars;
  assign run_o.count      = n;
  assign run_o.char_valid = run_valid;
  assign run_o.done       = item_i.end_of_text;

endmodule

// ===== hdl/mts_queue.sv =====
`include "markup_tag_stripper_core_assert.svh"

module mts_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mts_pkg::run_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mts_pkg::run_t head_o
);
  import mts_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  run_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Run storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  `MTS_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `MTS_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)
  `MTS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth))

endmodule

// ===== hdl/mts_back.sv =====
`include "markup_tag_stripper_core_assert.svh"

module mts_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  mts_pkg::run_t     head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mts_pkg::out_item_t out_item_o
);
  import mts_pkg::*;

  logic [RunCntW-1:0] idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q;
  logic               load;
  logic               last;

  // Load the output register whenever a run is queued and it is empty or being taken.
  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last  = (idx_q == head_i.count - RunCntW'(1));
  assign pop_o = load && last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last ? '0 : idx_q + RunCntW'(1);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_char    <= head_i.chars[idx_q];
      out_q.char_valid  <= head_i.char_valid;
      out_q.text_done   <= head_i.done && last;
      out_q.last_of_run <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `MTS_ASSERT_IMP(a_head_nonempty, clk_i, rst_ni, head_valid_i, head_i.count != '0)
  `MTS_ASSERT_IMP(a_idx_in_run, clk_i, rst_ni, head_valid_i, idx_q < head_i.count)
  `MTS_ASSERT_IMP(a_idle_idx_zero, clk_i, rst_ni, !head_valid_i, idx_q == '0)

endmodule
